// File: hw/rtl/ssa_pkg.sv
// Shared types and constants of the session slot allocator.
package ssa_pkg;

  localparam int unsigned IdW     = 32;
  localparam int unsigned IdxW    = 24;
  localparam int unsigned CntW    = 11;
  localparam int unsigned LsnW    = 8;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned StatusW = 2;

  localparam logic [IdxW-1:0] INDEX_MASK = 24'hFFFFFF;
  localparam logic [CntW-1:0] MAX_OPEN_RST = 11'd1024;

  typedef enum logic [CmdW-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_LOOKUP  = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  typedef enum logic {
    CFG_LISTENER = 1'b0,
    CFG_MAX_OPEN = 1'b1
  } cfg_idx_e;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_MOD   = 6'b000100,
    S_LOOK  = 6'b001000,
    S_SCAN  = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  typedef struct packed {
    logic            start;
    logic [IdxW-1:0] value;
  } mod_req_t;

endpackage

// File: hw/rtl/session_slot_allocator_core.sv
// Session slot allocator: round-robin connection slot table issuing session ids.
// After reset the block sweeps the slot table clean and accepts no request
// meanwhile; configuration writes are taken at any time. Each slot is one entry
// of a single table RAM holding a used bit and the stored id, read one entry per
// cycle. An allocate examines from 1 to SLOTS slots in the round-robin scan; an
// allocate refused at the open limit skips the scan. Lookup and release reduce
// the slot index by a mask when SLOTS is a power of two, and otherwise by a
// reciprocal multiply through registered product and remainder stages. One
// request is in flight at a time; a finished result waits in the output register
// while the next request is accepted.
module session_slot_allocator_core import ssa_pkg::*; #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [10:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] session_id
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [31:0] result_id, [42:32] open_now, zero fill
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  localparam int unsigned SlotW = SLOTS > 1 ? $clog2(SLOTS) : 1;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(SLOTS - 1);
  localparam int unsigned EntW = IdW + 1;

  state_e state_q, state_d;

  logic [CmdW-1:0]    cmd_q, cmd_d;
  logic [IdW-1:0]     id_q, id_d;
  logic [IdxW-1:0]    cand_q, cand_d;
  logic [SlotW-1:0]   slot_q, slot_d;
  logic [SlotW-1:0]   scan_cnt_q, scan_cnt_d;
  logic [SlotW-1:0]   clr_q, clr_d;
  logic [IdxW-1:0]    next_index_q, next_index_d;
  logic [SlotW-1:0]   next_slot_q, next_slot_d;
  logic [CntW-1:0]    open_q, open_d;
  logic [LsnW-1:0]    listener_q;
  logic [CntW-1:0]    max_open_q;
  logic [IdW-1:0]     res_id_q, res_id_d;
  logic [StatusW-1:0] res_status_q, res_status_d;
  logic               out_valid_q, out_valid_d;
  logic [IdW-1:0]     out_id_q;
  logic [StatusW-1:0] out_status_q;
  logic [CntW-1:0]    out_open_q;
  logic               out_load;

  logic               mem_we, mem_re;
  logic [SlotW-1:0]   mem_waddr, mem_raddr;
  logic [EntW-1:0]    mem_wdata, mem_rdata;

  mod_req_t           mod_req;
  logic               mod_done;
  logic [SlotW-1:0]   mod_rem;

  logic               in_accept;
  logic [SlotW-1:0]   slot_adv;
  logic               match;
  logic [IdW-1:0]     new_id;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign slot_adv = (cand_q == INDEX_MASK || slot_q == LastSlot) ? '0 : slot_q + 1'b1;
  assign match    = mem_rdata[IdW] && (mem_rdata[IdW-1:0] == id_q);
  assign new_id   = {listener_q, cand_q};

  assign mod_req.start = in_accept && (s_axis_tuser == CMD_LOOKUP ||
                                       s_axis_tuser == CMD_RELEASE);
  assign mod_req.value = s_axis_tdata[IdxW-1:0];

  assign out_load = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    id_d         = id_q;
    cand_d       = cand_q;
    slot_d       = slot_q;
    scan_cnt_d   = scan_cnt_q;
    clr_d        = clr_q;
    next_index_d = next_index_q;
    next_slot_d  = next_slot_q;
    open_d       = open_q;
    res_id_d     = res_id_q;
    res_status_d = res_status_q;
    mem_we       = 1'b0;
    mem_waddr    = slot_q;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = slot_adv;

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == LastSlot) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          cmd_d = s_axis_tuser;
          id_d  = s_axis_tdata;
          unique case (s_axis_tuser)
            CMD_ALLOC: begin
              if (open_q >= max_open_q) begin
                res_id_d     = '0;
                res_status_d = ST_FULL;
                state_d      = S_DONE;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = next_slot_q;
                cand_d     = next_index_q;
                slot_d     = next_slot_q;
                scan_cnt_d = '0;
                state_d    = S_SCAN;
              end
            end
            CMD_LOOKUP, CMD_RELEASE: begin
              state_d = S_MOD;
            end
            default: begin
              res_id_d     = s_axis_tdata;
              res_status_d = ST_MISS;
              state_d      = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (!mem_rdata[IdW]) begin
          mem_we       = 1'b1;
          mem_waddr    = slot_q;
          mem_wdata    = {1'b1, new_id};
          open_d       = open_q + 1'b1;
          next_index_d = cand_q + 1'b1;
          next_slot_d  = slot_adv;
          res_id_d     = new_id;
          res_status_d = ST_OK;
          state_d      = S_DONE;
        end else if (scan_cnt_q == LastSlot) begin
          res_id_d     = '0;
          res_status_d = ST_FULL;
          state_d      = S_DONE;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = slot_adv;
          cand_d     = cand_q + 1'b1;
          slot_d     = slot_adv;
          scan_cnt_d = scan_cnt_q + 1'b1;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          mem_re    = 1'b1;
          mem_raddr = mod_rem;
          slot_d    = mod_rem;
          state_d   = S_LOOK;
        end
      end
      S_LOOK: begin
        res_id_d     = id_q;
        res_status_d = match ? ST_OK : ST_MISS;
        if (cmd_q == CMD_RELEASE && match) begin
          mem_we    = 1'b1;
          mem_waddr = slot_q;
          mem_wdata = {1'b0, id_q};
          open_d    = open_q - 1'b1;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      next_index_q <= '0;
      next_slot_q  <= '0;
      open_q       <= '0;
      listener_q   <= '0;
      max_open_q   <= MAX_OPEN_RST;
      out_valid_q  <= 1'b0;
      scan_cnt_q   <= '0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      next_index_q <= next_index_d;
      next_slot_q  <= next_slot_d;
      open_q       <= open_d;
      out_valid_q  <= out_valid_d;
      scan_cnt_q   <= scan_cnt_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_LISTENER: listener_q <= cfg_data_i[LsnW-1:0];
          CFG_MAX_OPEN: max_open_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    id_q         <= id_d;
    cand_q       <= cand_d;
    slot_q       <= slot_d;
    res_id_q     <= res_id_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_id_q     <= res_id_q;
      out_status_q <= res_status_q;
      out_open_q   <= open_q;
    end
  end

  ssa_slot_mod #(
    .SLOTS (SLOTS)
  ) u_slot_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .done_o (mod_done),
    .rem_o  (mod_rem)
  );

  ssa_ram #(
    .WIDTH (EntW),
    .DEPTH (SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_open_q, out_id_q};
  assign m_axis_tuser  = out_status_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q != S_IDLE)
    else $error("accepted request did not start work");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_CLEAR || state_q == S_SCAN || state_q == S_LOOK))
    else $error("table write outside clear, scan or lookup");

  a_open_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (open_d != open_q) |-> (state_q == S_SCAN || state_q == S_LOOK))
    else $error("open count changed outside allocate or release");

  a_done_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && state_q == S_IDLE)
    else $error("result not presented after completion");

endmodule

// File: hw/rtl/ssa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ssa_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/ssa_slot_mod.sv
// Reduction of a 24-bit slot index modulo the slot count.
module ssa_slot_mod import ssa_pkg::*; #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  mod_req_t                                  req_i,
  output logic                                      done_o,
  output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] rem_o
);

  localparam int unsigned SlotW = SLOTS > 1 ? $clog2(SLOTS) : 1;
  localparam bit          IsPow2 = (SLOTS & (SLOTS - 1)) == 0;

  generate
    if (IsPow2) begin : g_mask
      logic [SlotW-1:0] rem_q;
      logic             done_q;

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          done_q <= 1'b0;
        end else begin
          done_q <= req_i.start;
        end
      end

      always_ff @(posedge clk_i) begin
        if (req_i.start) begin
          rem_q <= SlotW'(req_i.value & IdxW'(SLOTS - 1));
        end
      end

      assign done_o = done_q;
      assign rem_o  = rem_q;
    end else begin : g_recip
      // quotient estimate by reciprocal multiply, then one compare and subtract
      localparam int unsigned ShW  = IdxW + SlotW;
      localparam int unsigned RecW = IdxW + 1;
      localparam int unsigned PrdW = IdxW + RecW;
      localparam int unsigned QW   = PrdW - ShW;
      localparam logic [63:0]      RecipFull = (64'd1 << ShW) / 64'(SLOTS);
      localparam logic [RecW-1:0]  Recip     = RecipFull[RecW-1:0];
      localparam logic [SlotW-1:0] SlotsN    = SlotW'(SLOTS);
      localparam logic [SlotW:0]   SlotsW    = (SlotW + 1)'(SLOTS);

      logic             prod_vld_q;
      logic             done_q;
      logic [PrdW-1:0]  prod_q;
      logic [IdxW-1:0]  val_q;
      logic [SlotW:0]   r_q;
      logic [QW-1:0]    quot;
      logic [IdxW:0]    back;
      logic [IdxW:0]    diff;

      assign quot = prod_q[PrdW-1:ShW];
      assign back = quot * SlotsN;
      assign diff = {1'b0, val_q} - back;

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          prod_vld_q <= 1'b0;
          done_q     <= 1'b0;
        end else begin
          prod_vld_q <= req_i.start;
          done_q     <= prod_vld_q;
        end
      end

      always_ff @(posedge clk_i) begin
        if (req_i.start) begin
          val_q  <= req_i.value;
          prod_q <= req_i.value * Recip;
        end
        if (prod_vld_q) begin
          r_q <= diff[SlotW:0];
        end
      end

      assign done_o = done_q;
      assign rem_o  = (r_q >= SlotsW) ? SlotW'(r_q - SlotsW) : r_q[SlotW-1:0];
    end
  endgenerate

endmodule

// File: test/tb_session_slot_allocator_core.sv
// Self-checking testbench for the session slot allocator: table model, stimulus and checks.
module tb_session_slot_allocator_core import ssa_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS       = 1024;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 20000;

  typedef struct {
    logic [31:0] id;
    status_e     status;
    logic [10:0] open_now;
  } answer_t;

  class session_table_sb;
    bit          used[SLOTS];
    logic [31:0] sess[SLOTS];
    bit          seen[SLOTS];
    int          seen_q[$];
    int          live_q[$];
    logic [23:0] next_idx;
    logic [10:0] open_cnt;
    logic [7:0]  listener;
    logic [10:0] max_open;
    answer_t     answers_due[$];
    int          errors, n_req, n_alloc, n_full, n_hit, n_miss, peak;

    function new();
      next_idx = '0;
      open_cnt = '0;
      listener = '0;
      max_open = MAX_OPEN_RST;
    endfunction

    function void set_cfg(cfg_idx_e idx, logic [10:0] value);
      if (idx == CFG_LISTENER) listener = value[7:0];
      else max_open = value;
    endfunction

    function void push(logic [31:0] id, status_e st);
      answer_t a;
      a.id       = id;
      a.status   = st;
      a.open_now = open_cnt;
      answers_due.push_back(a);
      if (st == ST_FULL) n_full++;
      else if (st == ST_MISS) n_miss++;
      if (int'(open_cnt) > peak) peak = int'(open_cnt);
    endfunction

    function void allocate();
      logic [23:0] cand;
      int          s;
      if (open_cnt >= max_open) begin
        push('0, ST_FULL);
        return;
      end
      for (int i = 0; i < SLOTS; i++) begin
        cand = next_idx + 24'(i);
        s    = int'(cand % SLOTS);
        if (!used[s]) begin
          used[s] = 1'b1;
          sess[s] = {listener, cand};
          if (!seen[s]) begin
            seen[s] = 1'b1;
            seen_q.push_back(s);
          end
          live_q.push_back(s);
          open_cnt = open_cnt + 11'd1;
          next_idx = cand + 24'd1;
          n_alloc++;
          push({listener, cand}, ST_OK);
          return;
        end
      end
      push('0, ST_FULL);
    endfunction

    function void note_request(cmd_e cmd, logic [31:0] id);
      int s;
      bit hit;
      n_req++;
      s   = int'(id[23:0] % SLOTS);
      hit = used[s] && sess[s] == id;
      case (cmd)
        CMD_ALLOC: allocate();
        CMD_LOOKUP: begin
          if (hit) n_hit++;
          push(id, hit ? ST_OK : ST_MISS);
        end
        CMD_RELEASE: begin
          if (hit) begin
            used[s]  = 1'b0;
            open_cnt = open_cnt - 11'd1;
            for (int j = 0; j < live_q.size(); j++) begin
              if (live_q[j] == s) begin
                live_q.delete(j);
                break;
              end
            end
            n_hit++;
          end
          push(id, hit ? ST_OK : ST_MISS);
        end
        default: push(id, ST_MISS);
      endcase
    endfunction

    function void check_answer(logic [31:0] id, logic [1:0] st, logic [10:0] open_now);
      answer_t e;
      if (answers_due.size() == 0) begin
        $error("unexpected result: result_id %h status %0d open_now %0d", id, st, open_now);
        errors++;
        return;
      end
      e = answers_due.pop_front();
      if (id !== e.id) begin
        $error("result_id: expected %h, got %h", e.id, id);
        errors++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        errors++;
      end
      if (open_now !== e.open_now) begin
        $error("open_now: expected %0d, got %0d", e.open_now, open_now);
        errors++;
      end
    endfunction

    // live ids, corrupted live ids, stale ids and raw ids, kept on slots already written
    function logic [31:0] pick_target();
      logic [31:0] id;
      int          r;
      r = $urandom_range(0, 99);
      if (r < 55 && live_q.size() > 0)
        id = sess[live_q[$urandom_range(0, live_q.size() - 1)]];
      else if (r < 75 && live_q.size() > 0)
        id = sess[live_q[$urandom_range(0, live_q.size() - 1)]] ^ (32'h1 << $urandom_range(0, 31));
      else if (r < 88)
        id = sess[seen_q[$urandom_range(0, seen_q.size() - 1)]];
      else
        id = $urandom;
      if (!seen[int'(id[23:0] % SLOTS)])
        id[9:0] = 10'(seen_q[$urandom_range(0, seen_q.size() - 1)]);
      return id;
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [10:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  session_table_sb sb;
  bit steady;
  bit hold_req;
  int stall_left;
  int quiet;

  session_slot_allocator_core #(.SLOTS(SLOTS)) u_top (.*);

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb_session_slot_allocator_core: errors");
        $finish;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_answer(m_axis_tdata[31:0], m_axis_tuser, m_axis_tdata[42:32]);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!steady && $urandom_range(0, 99) < 15) begin
        stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 50) : $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_req(cmd_e cmd, logic [31:0] id);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= id;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(cmd, id);
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.answers_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [10:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    sb.set_cfg(idx, value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_mix(int n, int p_alloc, int p_look, int hold_at);
    int   r;
    cmd_e cmd;
    for (int k = 0; k < n; k++) begin
      steady = ((k / 100) % 4 == 3);
      if (k == hold_at) hold_req = 1'b1;
      r = $urandom_range(0, 99);
      if (r < p_alloc || sb.seen_q.size() == 0) cmd = CMD_ALLOC;
      else if (r < p_alloc + p_look) cmd = CMD_LOOKUP;
      else cmd = CMD_RELEASE;
      send_req(cmd, (cmd == CMD_ALLOC) ? 32'($urandom) : sb.pick_target());
    end
    steady = 1'b0;
  endtask

  initial begin
    sb            = new();
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_LISTENER;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_ALLOC;
    m_axis_tready <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    cfg_write(CFG_LISTENER, 11'd0);
    cfg_write(CFG_MAX_OPEN, 11'd1024);
    send_req(CMD_ALLOC, 32'hFFFF_FFFF);
    send_req(CMD_LOOKUP, 32'h0000_0000);
    send_req(CMD_LOOKUP, 32'h0100_0000);
    send_req(CMD_RELEASE, 32'h0000_0400);
    send_req(CMD_RELEASE, 32'h0000_0000);
    send_req(CMD_RELEASE, 32'h0000_0000);
    send_req(CMD_LOOKUP, 32'h0000_0000);
    send_req(CMD_ALLOC, 32'h0000_0000);
    send_req(CMD_ALLOC, 32'h5555_5555);
    send_req(CMD_LOOKUP, 32'hFFFF_FC01);
    drain();

    cfg_write(CFG_LISTENER, 11'd255);
    cfg_write(CFG_MAX_OPEN, 11'd1);
    send_req(CMD_ALLOC, 32'hAAAA_AAAA);
    send_req(CMD_RELEASE, 32'h0000_0001);
    send_req(CMD_RELEASE, 32'h0000_0002);
    send_req(CMD_ALLOC, 32'h0000_0000);
    send_req(CMD_ALLOC, 32'h0000_0000);
    send_req(CMD_LOOKUP, 32'hFF00_0003);
    send_req(CMD_RELEASE, 32'hFF00_0003);
    drain();

    cfg_write(CFG_LISTENER, 11'($urandom_range(1, 254)));
    cfg_write(CFG_MAX_OPEN, 11'd1024);
    run_mix(300, 40, 30, 60);
    drain();

    cfg_write(CFG_LISTENER, 11'($urandom_range(0, 255)));
    run_mix(1250, 88, 6, 900);
    drain();

    cfg_write(CFG_LISTENER, 11'($urandom_range(0, 255)));
    cfg_write(CFG_MAX_OPEN, 11'($urandom_range(1, 1023)));
    run_mix(250, 25, 25, -1);
    drain();
    repeat (30) @(posedge clk_i);

    $display("summary: %0d requests, %0d allocations, %0d refused as full, %0d hits, %0d misses",
             sb.n_req, sb.n_alloc, sb.n_full, sb.n_hit, sb.n_miss);
    $display("summary: peak open count %0d, final open count %0d, %0d slots ever used",
             sb.peak, sb.open_cnt, sb.seen_q.size());
    if (sb.errors == 0 && sb.answers_due.size() == 0) begin
      $display("tb_session_slot_allocator_core: clean");
    end else begin
      $display("tb_session_slot_allocator_core: errors");
    end
    $finish;
  end

endmodule
